// ===== sv/xor_parity_fec_generator_macros.svh =====
// assertion macros for the xor parity fec generator
// used by modules that check their own logic; needs clk_i and rst_ni in scope
`ifndef XOR_PARITY_FEC_GENERATOR_MACROS_SVH
`define XOR_PARITY_FEC_GENERATOR_MACROS_SVH
`ifndef SYNTHESIS
`define XPF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define XPF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define XPF_ASSERT_NOW(lbl, ante, cons, msg)
`define XPF_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== sv/xpf_pkg.sv =====
// shared constants, types and helpers of the xor parity fec generator
// no dependencies
package xpf_pkg;

  localparam int PACKET_BYTES  = 1500;
  localparam int HEADER_BYTES  = 17;
  localparam int MAX_PACKETS   = 4096;
  localparam int PAYLOAD_BYTES = PACKET_BYTES - HEADER_BYTES;

  localparam int BYTE_W   = 8;
  localparam int FRAME_W  = 31;
  localparam int PNUM_W   = 12;
  localparam int TOTAL_W  = 13;
  localparam int POS_W    = 11;
  localparam int SESS_W   = 32;
  localparam int GROUP_W  = 13;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // divider steps: one per dividend bit
  localparam int DIV_STEPS = PNUM_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  // register indexes
  localparam logic REG_GROUP_SIZE  = 1'b0;
  localparam logic REG_SESSION_TAG = 1'b1;

  // classified byte handed from front to back
  typedef struct packed {
    logic [BYTE_W-1:0]  data;
    logic [FRAME_W-1:0] frame;
    logic [PNUM_W-1:0]  total_m1;
    logic [POS_W-1:0]   pos;
    logic               pnum_last;
    logic               frame_start;
    logic               last_pos;
  } xpf_item_t;

  // divider request
  typedef struct packed {
    logic               start;
    logic [PNUM_W-1:0]  dividend;
    logic [GROUP_W-1:0] divisor;
  } xpf_div_req_t;

  // total clamped to 1..MAX_PACKETS
  function automatic logic [TOTAL_W-1:0] eff_total(input logic [TOTAL_W-1:0] t);
    logic [TOTAL_W-1:0] r;
    if (t == '0) begin
      r = TOTAL_W'(1);
    end else if (t > TOTAL_W'(MAX_PACKETS)) begin
      r = TOTAL_W'(MAX_PACKETS);
    end else begin
      r = t;
    end
    return r;
  endfunction

  // group size of zero acts as one
  function automatic logic [GROUP_W-1:0] eff_group(input logic [GROUP_W-1:0] g);
    return (g == '0) ? GROUP_W'(1) : g;
  endfunction

endpackage

// ===== sv/xpf_front.sv =====
// front part: accepts payload bytes, tracks the byte position, classifies
// depends on xpf_pkg
module xpf_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [xpf_pkg::BYTE_W-1:0]  payload_byte_i,
  input  logic [xpf_pkg::FRAME_W-1:0] frame_number_i,
  input  logic [xpf_pkg::PNUM_W-1:0]  packet_number_i,
  input  logic [xpf_pkg::TOTAL_W-1:0] packet_total_i,
  input  logic                        q_full_i,
  output logic                        q_push_o,
  output xpf_pkg::xpf_item_t          q_item_o
);
  import xpf_pkg::*;

  logic [POS_W-1:0]   pos_q, pos_d;
  logic [TOTAL_W-1:0] total_eff;
  logic               last_pos;
  logic               accept;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign q_push_o   = accept;

  // classification of the current byte
  assign total_eff = eff_total(packet_total_i);
  assign last_pos  = (pos_q == POS_W'(PAYLOAD_BYTES - 1));

  always_comb begin
    q_item_o.data        = payload_byte_i;
    q_item_o.frame       = frame_number_i;
    q_item_o.total_m1    = PNUM_W'(total_eff - TOTAL_W'(1));
    q_item_o.pos         = pos_q;
    q_item_o.pnum_last   = ({1'b0, packet_number_i} + TOTAL_W'(1)) >= total_eff;
    q_item_o.frame_start = (pos_q == '0) && (packet_number_i == '0);
    q_item_o.last_pos    = last_pos;
  end

  // payload position counter
  always_comb begin
    pos_d = pos_q;
    if (accept) begin
      pos_d = last_pos ? '0 : pos_q + POS_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule

// ===== sv/xpf_fifo.sv =====
// short queue of classified bytes between front and back
// depends on xpf_pkg
module xpf_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  xpf_pkg::xpf_item_t push_item_i,
  input  logic               pop_i,
  output logic               full_o,
  output logic               head_valid_o,
  output xpf_pkg::xpf_item_t head_item_o
);
  import xpf_pkg::*;

  xpf_item_t           slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]   count_q, count_d;

  assign full_o       = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_item_o  = slot_q[rd_ptr_q];

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + QCNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage slots
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// ===== sv/xpf_div.sv =====
// iterative restoring divider, one quotient bit per cycle
// depends on xpf_pkg
module xpf_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  xpf_pkg::xpf_div_req_t       req_i,
  output logic                        busy_o,
  output logic                        done_o,
  output logic [xpf_pkg::PNUM_W-1:0]  quotient_o
);
  import xpf_pkg::*;

  logic [GROUP_W-1:0]   rem_q, rem_d;
  logic [PNUM_W-1:0]    quo_q, quo_d;
  logic [GROUP_W-1:0]   div_q, div_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 done_q, done_d;
  logic [GROUP_W:0]     trial;

  assign busy_o     = (cnt_q != '0);
  assign done_o     = done_q;
  assign quotient_o = quo_q;

  // shift in the next dividend bit and try a subtract
  assign trial = {rem_q, quo_q[PNUM_W-1]};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    div_d  = div_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d = '0;
      quo_d = req_i.dividend;
      div_d = req_i.divisor;
      cnt_d = DIV_CNT_W'(DIV_STEPS);
    end else if (cnt_q != '0) begin
      if (trial >= {1'b0, div_q}) begin
        rem_d = GROUP_W'(trial - {1'b0, div_q});
        quo_d = {quo_q[PNUM_W-2:0], 1'b1};
      end else begin
        rem_d = GROUP_W'(trial);
        quo_d = {quo_q[PNUM_W-2:0], 1'b0};
      end
      cnt_d  = cnt_q - DIV_CNT_W'(1);
      done_d = (cnt_q == DIV_CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    div_q <= div_d;
  end

endmodule

// ===== sv/xpf_back.sv =====
// back part: group bookkeeping, parity store and the result register
// depends on xpf_pkg, xpf_div and the assertion macro header
module xpf_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [xpf_pkg::GROUP_W-1:0] group_eff_i,
  input  logic [xpf_pkg::SESS_W-1:0]  session_i,
  input  logic                        head_valid_i,
  input  xpf_pkg::xpf_item_t          head_item_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [xpf_pkg::BYTE_W-1:0]  parity_byte_o,
  output logic [xpf_pkg::POS_W-1:0]   byte_offset_o,
  output logic [xpf_pkg::PNUM_W-1:0]  parity_index_o,
  output logic [xpf_pkg::TOTAL_W-1:0] parity_total_o,
  output logic [xpf_pkg::FRAME_W-1:0] frame_out_o,
  output logic [xpf_pkg::SESS_W-1:0]  session_out_o,
  output logic                        last_byte_o
);
  import xpf_pkg::*;
  `include "xor_parity_fec_generator_macros.svh"

  typedef enum logic [1:0] {
    ST_RUN = 2'b01,
    ST_DIV = 2'b10
  } bk_state_e;

  bk_state_e            state_q, state_d;
  logic                 have_q, have_d;
  xpf_div_req_t         div_req;
  logic                 div_busy, div_done;
  logic [PNUM_W-1:0]    div_quo;

  logic [BYTE_W-1:0]    store_mem [PAYLOAD_BYTES];
  logic [BYTE_W-1:0]    rdata_q;

  logic                 s2_valid_q, s2_valid_d;
  xpf_item_t            s2_item_q;
  logic [TOTAL_W-1:0]   s2_count_q;

  logic [GROUP_W-1:0]   fill_q, fill_d;
  logic [PNUM_W-1:0]    pcnt_q, pcnt_d;
  logic [TOTAL_W-1:0]   ptot_q, ptot_d;

  logic [GROUP_W-1:0]   fill_cur;
  logic [PNUM_W-1:0]    pcnt_cur;
  logic [TOTAL_W-1:0]   ptot_cur;
  logic                 first, group_last;
  logic [BYTE_W-1:0]    acc;
  logic                 s2_adv, out_load, pop;
  logic                 out_valid_q, out_valid_d;

  // parity packet count of the frame, one division per frame start
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = head_item_i.total_m1;
    div_req.divisor  = group_eff_i;
    state_d          = state_q;
    have_d           = have_q;
    case (state_q)
      ST_RUN: begin
        if (head_valid_i && head_item_i.frame_start && !have_q && !div_busy) begin
          div_req.start = 1'b1;
          state_d       = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          have_d  = 1'b1;
          state_d = ST_RUN;
        end
      end
      default: begin
        state_d = ST_RUN;
      end
    endcase
    if (pop && head_item_i.frame_start) begin
      have_d = 1'b0;
    end
  end

  xpf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // stage two: combine with stored parity
  always_comb begin
    fill_cur   = s2_item_q.frame_start ? '0 : fill_q;
    pcnt_cur   = s2_item_q.frame_start ? '0 : pcnt_q;
    ptot_cur   = s2_item_q.frame_start ? s2_count_q : ptot_q;
    first      = (fill_cur == '0);
    group_last = (({1'b0, fill_cur} + (GROUP_W + 1)'(1)) >= {1'b0, group_eff_i})
                 || s2_item_q.pnum_last;
    acc        = first ? s2_item_q.data : (rdata_q ^ s2_item_q.data);
  end

  assign s2_adv   = s2_valid_q && (!group_last || !out_valid_q || out_ready_i);
  assign out_load = s2_adv && group_last;
  assign pop      = head_valid_i && (state_q == ST_RUN) && (!s2_valid_q || s2_adv)
                    && (!head_item_i.frame_start || have_q);
  assign pop_o    = pop;

  // group counters
  always_comb begin
    fill_d = fill_q;
    pcnt_d = pcnt_q;
    ptot_d = ptot_q;
    if (s2_adv) begin
      ptot_d = ptot_cur;
      fill_d = fill_cur;
      pcnt_d = pcnt_cur;
      if (s2_item_q.last_pos) begin
        if (group_last) begin
          fill_d = '0;
          pcnt_d = pcnt_cur + PNUM_W'(1);
        end else begin
          fill_d = fill_cur + GROUP_W'(1);
        end
      end
    end
  end

  always_comb begin
    s2_valid_d = s2_valid_q;
    if (pop) begin
      s2_valid_d = 1'b1;
    end else if (s2_adv) begin
      s2_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      have_q      <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      fill_q      <= '0;
      pcnt_q      <= '0;
      ptot_q      <= TOTAL_W'(1);
    end else begin
      state_q     <= state_d;
      have_q      <= have_d;
      s2_valid_q  <= s2_valid_d;
      out_valid_q <= out_valid_d;
      fill_q      <= fill_d;
      pcnt_q      <= pcnt_d;
      ptot_q      <= ptot_d;
    end
  end

  // stage two payload
  always_ff @(posedge clk_i) begin
    if (pop) begin
      s2_item_q  <= head_item_i;
      s2_count_q <= {1'b0, div_quo} + TOTAL_W'(1);
    end
  end

  // parity store: read at pop, write when stage two retires
  always_ff @(posedge clk_i) begin
    if (pop) begin
      rdata_q <= store_mem[head_item_i.pos];
    end
    if (s2_adv) begin
      store_mem[s2_item_q.pos] <= acc;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      parity_byte_o  <= acc;
      byte_offset_o  <= s2_item_q.pos;
      parity_index_o <= pcnt_cur;
      parity_total_o <= ptot_cur;
      frame_out_o    <= s2_item_q.frame;
      session_out_o  <= session_i;
      last_byte_o    <= s2_item_q.last_pos;
    end
  end

  assign out_valid_o = out_valid_q;

  `XPF_ASSERT_NOW(a_start_needs_quotient, pop && head_item_i.frame_start, have_q,
    "frame start popped before its parity count was ready")
  `XPF_ASSERT_NOW(a_no_pop_while_dividing, state_q == ST_DIV, !pop,
    "byte popped while the divider runs")
  `XPF_ASSERT_NEXT(a_counter_steps,
    s2_adv && s2_item_q.last_pos && group_last && !s2_item_q.frame_start,
    pcnt_q == $past(pcnt_q) + PNUM_W'(1),
    "parity index did not advance at the end of a group")

endmodule

// ===== sv/xor_parity_fec_generator.sv =====
// top level of the xor parity fec generator: config registers and the parts
// depends on xpf_pkg, xpf_front, xpf_fifo, xpf_back
//
// channel   direction  handshake                 payload
// input     in         in_valid_i / in_ready_o   payload_byte, frame, packet no, total
// output    out        out_valid_o / out_ready_i parity byte, offset, index, total, ids
// config    in         psel / penable / pwrite   group_size at 0x0, session_tag at 0x4
//
// one payload byte per cycle unless a full result register waits on out_ready_i;
// a frame start byte waits while the divider computes the parity packet count.
// reset clears the counters; the parity store is not cleared.
// a four-entry queue lets the input run on while the result register waits.
module xor_parity_fec_generator (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [xpf_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [xpf_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [xpf_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [xpf_pkg::BYTE_W-1:0]     payload_byte_i,
  input  logic [xpf_pkg::FRAME_W-1:0]    frame_number_i,
  input  logic [xpf_pkg::PNUM_W-1:0]     packet_number_i,
  input  logic [xpf_pkg::TOTAL_W-1:0]    packet_total_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [xpf_pkg::BYTE_W-1:0]     parity_byte_o,
  output logic [xpf_pkg::POS_W-1:0]      byte_offset_o,
  output logic [xpf_pkg::PNUM_W-1:0]     parity_index_o,
  output logic [xpf_pkg::TOTAL_W-1:0]    parity_total_o,
  output logic [xpf_pkg::FRAME_W-1:0]    frame_out_o,
  output logic [xpf_pkg::SESS_W-1:0]     session_out_o,
  output logic                           last_byte_o
);
  import xpf_pkg::*;

  logic [GROUP_W-1:0] group_size_q;
  logic [SESS_W-1:0]  session_tag_q;
  logic               cfg_wr;
  xpf_item_t          push_item, head_item;
  logic               push, pop, q_full, head_valid;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_size_q  <= GROUP_W'(10);
      session_tag_q <= '0;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_GROUP_SIZE:  group_size_q  <= pwdata[GROUP_W-1:0];
        REG_SESSION_TAG: session_tag_q <= pwdata[SESS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_GROUP_SIZE:  prdata = CFG_DATA_W'(group_size_q);
      REG_SESSION_TAG: prdata = CFG_DATA_W'(session_tag_q);
      default:         prdata = '0;
    endcase
  end

  xpf_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .payload_byte_i  (payload_byte_i),
    .frame_number_i  (frame_number_i),
    .packet_number_i (packet_number_i),
    .packet_total_i  (packet_total_i),
    .q_full_i        (q_full),
    .q_push_o        (push),
    .q_item_o        (push_item)
  );

  xpf_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_item_i  (push_item),
    .pop_i        (pop),
    .full_o       (q_full),
    .head_valid_o (head_valid),
    .head_item_o  (head_item)
  );

  xpf_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .group_eff_i    (eff_group(group_size_q)),
    .session_i      (session_tag_q),
    .head_valid_i   (head_valid),
    .head_item_i    (head_item),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .parity_byte_o  (parity_byte_o),
    .byte_offset_o  (byte_offset_o),
    .parity_index_o (parity_index_o),
    .parity_total_o (parity_total_o),
    .frame_out_o    (frame_out_o),
    .session_out_o  (session_out_o),
    .last_byte_o    (last_byte_o)
  );

endmodule
